// File: src/aes128_block_cipher_unit_macros.svh
// Assertion shorthands shared by the cipher unit.
`ifndef AES128_BLOCK_CIPHER_UNIT_MACROS_SVH
`define AES128_BLOCK_CIPHER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define AES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/aes128_pkg.sv
package aes128_pkg;

  localparam int ROUNDS = 10;
  localparam int NUM_RK = ROUNDS + 1;
  localparam logic [3:0] LAST_STEP = 4'(ROUNDS);
  localparam logic [7:0] RCON_INIT = 8'h01;

  // Shift control for one ring cell.
  typedef struct packed {
    logic fwd;
    logic back;
  } cell_ctl_t;

  // Step control for the round unit.
  typedef struct packed {
    logic load;
    logic step;
    logic first;
    logic last;
    logic decrypt;
  } rnd_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] RSBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the state sits at bits 127-8i down.
  function automatic logic [127:0] shift_layer(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int src;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? (r + 4 * ((c - r) & 3)) : (r + 4 * ((c + r) & 3));
        t[127 - 8 * (r + 4 * c) -: 8] = s[127 - 8 * src -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] sub_layer(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0] b;
    t = '0;
    for (int i = 0; i < 16; i++) begin
      b = s[127 - 8 * i -: 8];
      t[127 - 8 * i -: 8] = inv ? RSBOX[b] : SBOX[b];
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_layer(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m0, m1, m2, m3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j] = s[127 - 8 * (4 * c + j) -: 8];
        x2[j] = xtime(a[j]);
        x4[j] = xtime(x2[j]);
        x8[j] = xtime(x4[j]);
      end
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          m0 = x8[r] ^ x4[r] ^ x2[r];
          m1 = x8[(r + 1) & 3] ^ x2[(r + 1) & 3] ^ a[(r + 1) & 3];
          m2 = x8[(r + 2) & 3] ^ x4[(r + 2) & 3] ^ a[(r + 2) & 3];
          m3 = x8[(r + 3) & 3] ^ a[(r + 3) & 3];
        end else begin
          m0 = x2[r];
          m1 = x2[(r + 1) & 3] ^ a[(r + 1) & 3];
          m2 = a[(r + 2) & 3];
          m3 = a[(r + 3) & 3];
        end
        t[127 - 8 * (4 * c + r) -: 8] = m0 ^ m1 ^ m2 ^ m3;
      end
    end
    return t;
  endfunction

  // One step of the key schedule: round key r to round key r+1.
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// File: src/aes128_cell.sv
module aes128_cell (
  input  logic                  clk,
  input  aes128_pkg::cell_ctl_t ctl,
  input  logic [127:0]          from_left,
  input  logic [127:0]          from_right,
  output logic [127:0]          q
);
  import aes128_pkg::*;

  // Take the neighbor's round key in the direction of rotation
  always_ff @(posedge clk) begin
    if (ctl.fwd) begin
      q <= from_right;
    end else if (ctl.back) begin
      q <= from_left;
    end
  end

endmodule

// File: src/aes128_keysched.sv
module aes128_keysched (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] key,
  output logic         push,
  output logic [127:0] rk
);
  import aes128_pkg::*;

  logic [127:0] cur;
  logic [7:0]   rc;
  logic [3:0]   cnt;
  logic         active;

  // Restart on every key write, then emit one round key per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (active) begin
      cnt <= cnt + 4'd1;
      if (cnt == LAST_STEP) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur <= key;
      rc  <= RCON_INIT;
    end else if (active) begin
      cur <= next_key(cur, rc);
      rc  <= xtime(rc);
    end
  end

  assign push = active;
  assign rk   = cur;

endmodule

// File: src/aes128_round.sv
module aes128_round (
  input  logic                 clk,
  input  aes128_pkg::rnd_ctl_t ctl,
  input  logic [127:0]         block,
  input  logic [127:0]         rk,
  output logic [127:0]         state
);
  import aes128_pkg::*;

  logic [127:0] sh, sb, enc_v, dec_v, state_next;

  // One cipher round (or the initial key add) per cycle while step is high, forward or inverse
  always_comb begin
    sh    = shift_layer(state, ctl.decrypt);
    sb    = sub_layer(sh, ctl.decrypt);
    enc_v = (ctl.last ? sb : mix_layer(sb, 1'b0)) ^ rk;
    dec_v = ctl.last ? (sb ^ rk) : mix_layer(sb ^ rk, 1'b1);
    if (ctl.first) begin
      state_next = state ^ rk;
    end else if (ctl.decrypt) begin
      state_next = dec_v;
    end else begin
      state_next = enc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      state <= block;
    end else if (ctl.step) begin
      state <= state_next;
    end
  end

endmodule

// File: src/aes128_block_cipher_unit.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+--------------------------------------
// input    | in_valid / in_stall | mode, block_high, block_low
// output   | out_valid/out_stall | result_high, result_low
// config   | cfg_we              | cfg_index, cfg_data (key halves)
//
// A block is loaded at its accepting edge, then takes eleven steps of the single round
// unit (initial key add and ten rounds) and one hand-off into the output register;
// the next block is accepted only after that hand-off.
// A key write starts an expansion of the eleven round keys into the ring, with in_stall high.
// Reset is synchronous and clears control and the key registers; the round keys are
// undefined until the first key write. A stalled output holds the result while the
// next block is already accepted and worked on.
module aes128_block_cipher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  import aes128_pkg::*;
  `include "aes128_block_cipher_unit_macros.svh"

  typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  state_t       state;
  logic [3:0]   cnt;
  logic         decrypt;
  logic [63:0]  key_high, key_low;
  logic [127:0] key_next;
  logic         kpush;
  logic [127:0] knew;
  logic [127:0] rk [NUM_RK];
  logic [127:0] cur_rk;
  logic [127:0] rstate;
  logic         accept;
  cell_ctl_t    cctl;
  rnd_ctl_t     rctl;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != IDLE) || kpush;

  // Key registers and the key value that starts expansion
  always_comb begin
    key_next = {key_high, key_low};
    case (cfg_index)
      CFG_KEY_HIGH: key_next = {cfg_data, key_low};
      CFG_KEY_LOW:  key_next = {key_high, cfg_data};
      default:      key_next = {key_high, key_low};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      key_high <= key_next[127:64];
      key_low  <= key_next[63:0];
    end
  end

  aes128_keysched u_ks (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_we),
    .key   (key_next),
    .push  (kpush),
    .rk    (knew)
  );

  // Rotate the ring forward for encryption and fill, backward for decryption
  assign cctl.fwd  = kpush || ((state == RUN) && !decrypt);
  assign cctl.back = (state == RUN) && decrypt;

  for (genvar i = 0; i < NUM_RK; i++) begin : g_ring
    logic [127:0] left_in, right_in;
    if (i == 0) begin : g_head
      assign left_in = rk[NUM_RK - 1];
    end else begin : g_mid_l
      assign left_in = rk[i - 1];
    end
    if (i == NUM_RK - 1) begin : g_tail
      assign right_in = kpush ? knew : rk[0];
    end else begin : g_mid_r
      assign right_in = rk[i + 1];
    end
    aes128_cell u_cell (
      .clk        (clk),
      .ctl        (cctl),
      .from_left  (left_in),
      .from_right (right_in),
      .q          (rk[i])
    );
  end

  assign cur_rk = decrypt ? rk[NUM_RK - 1] : rk[0];

  assign rctl.load    = accept;
  assign rctl.step    = (state == RUN);
  assign rctl.first   = (cnt == 4'd0);
  assign rctl.last    = (cnt == LAST_STEP);
  assign rctl.decrypt = decrypt;

  aes128_round u_round (
    .clk   (clk),
    .ctl   (rctl),
    .block ({block_high, block_low}),
    .rk    (cur_rk),
    .state (rstate)
  );

  // Sequence the rounds and hand the result to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            state   <= RUN;
            cnt     <= '0;
            decrypt <= mode;
          end
        end
        RUN: begin
          cnt <= cnt + 4'd1;
          if (cnt == LAST_STEP) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            result_high <= rstate[127:64];
            result_low  <= rstate[63:0];
            state       <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `AES_ASSERT_NEXT(a_accept_runs, accept, state == RUN, "accepted block did not start")
  `AES_ASSERT_NEXT(a_last_done, (state == RUN) && (cnt == LAST_STEP), state == DONE,
    "round sequence did not finish after the last round")
  `AES_ASSERT_NOW(a_out_from_done, out_valid && !$past(out_valid), $past(state == DONE),
    "result appeared without a finished block")

endmodule

// File: bench/aes128_block_cipher_checker.sv
`timescale 1ns / 1ps

module aes128_block_cipher_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        mode,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] result_high,
  input  logic [63:0] result_low,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  output int          failures,
  output int          pending
);

  typedef logic [7:0] state_t [16];

  logic [7:0]   fwd_sub [256];
  logic [7:0]   inv_sub [256];
  logic [63:0]  cipher_key_high;
  logic [63:0]  cipher_key_low;
  state_t       sched [11];
  logic [127:0] cipher_blocks [$];

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p = p ^ a;
      a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic logic [7:0] rot8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  // Build both substitution tables from the field inverse and affine map.
  initial begin
    logic [7:0] x, r, b, y;
    for (int i = 0; i < 256; i++) begin
      x = 8'(i);
      r = 8'h01;
      for (int e = 0; e < 254; e++) r = gmul(r, x);
      b = r;
      y = b ^ rot8(b, 1) ^ rot8(b, 2) ^ rot8(b, 3) ^ rot8(b, 4) ^ 8'h63;
      fwd_sub[i] = y;
      inv_sub[y] = x;
    end
  end

  function automatic state_t to_state(input logic [127:0] v);
    state_t s;
    for (int i = 0; i < 16; i++) s[i] = v[127 - 8 * i -: 8];
    return s;
  endfunction

  function automatic logic [127:0] from_state(input state_t s);
    logic [127:0] v;
    for (int i = 0; i < 16; i++) v[127 - 8 * i -: 8] = s[i];
    return v;
  endfunction

  // Expand the current key into the eleven round keys.
  task automatic expand_schedule();
    logic [7:0] w [44][4];
    logic [7:0] t [4];
    logic [7:0] f, rc;
    state_t k;
    k = to_state({cipher_key_high, cipher_key_low});
    rc = 8'h01;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) w[i][j] = k[4 * i + j];
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) t[j] = w[i - 1][j];
      if ((i % 4) == 0) begin
        f = t[0];
        t[0] = fwd_sub[t[1]] ^ rc;
        t[1] = fwd_sub[t[2]];
        t[2] = fwd_sub[t[3]];
        t[3] = fwd_sub[f];
        rc = gmul(rc, 8'h02);
      end
      for (int j = 0; j < 4; j++) w[i][j] = w[i - 4][j] ^ t[j];
    end
    for (int r = 0; r < 11; r++)
      for (int j = 0; j < 16; j++) sched[r][j] = w[4 * r + j / 4][j % 4];
  endtask

  function automatic state_t add_rk(input state_t s, input int r);
    for (int i = 0; i < 16; i++) s[i] = s[i] ^ sched[r][i];
    return s;
  endfunction

  function automatic state_t subst(input state_t s, input logic inverse);
    for (int i = 0; i < 16; i++) s[i] = inverse ? inv_sub[s[i]] : fwd_sub[s[i]];
    return s;
  endfunction

  function automatic state_t rows(input state_t s, input logic inverse);
    state_t t;
    int o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        o = r + 4 * ((c + r) % 4);
        if (inverse) t[o] = s[r + 4 * c];
        else t[r + 4 * c] = s[o];
      end
    return t;
  endfunction

  function automatic state_t columns(input state_t s, input logic inverse);
    logic [7:0] m [4];
    logic [7:0] a [4];
    logic [7:0] v;
    if (inverse) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) a[j] = s[4 * c + j];
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int j = 0; j < 4; j++) v = v ^ gmul(m[(j - r + 4) % 4], a[j]);
        s[4 * c + r] = v;
      end
    end
    return s;
  endfunction

  function automatic logic [127:0] cipher_block(input logic dec, input logic [127:0] din);
    state_t s;
    s = to_state(din);
    if (!dec) begin
      s = add_rk(s, 0);
      for (int r = 1; r < 10; r++) s = add_rk(columns(rows(subst(s, 0), 0), 0), r);
      s = add_rk(rows(subst(s, 0), 0), 10);
    end else begin
      s = subst(rows(add_rk(s, 10), 1), 1);
      for (int r = 9; r > 0; r--) s = subst(rows(columns(add_rk(s, r), 1), 1), 1);
      s = add_rk(s, 0);
    end
    return from_state(s);
  endfunction

  // Track key writes, predict accepted blocks, compare delivered results.
  always @(posedge clk) begin
    logic [127:0] want;
    if (rst) begin
      cipher_key_high = '0;
      cipher_key_low = '0;
      cipher_blocks.delete();
      failures = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index) cipher_key_low = cfg_data;
        else cipher_key_high = cfg_data;
        expand_schedule();
      end
      if (in_valid && !in_stall)
        cipher_blocks = {cipher_blocks, cipher_block(mode, {block_high, block_low})};
      if (out_valid && !out_stall) begin
        if (cipher_blocks.size() == 0) begin
          $error("result transaction with no block outstanding");
          failures++;
        end else begin
          want = cipher_blocks.pop_front();
          if (result_high !== want[127:64]) begin
            $error("result_high expected %h actual %h", want[127:64], result_high);
            failures++;
          end
          if (result_low !== want[63:0]) begin
            $error("result_low expected %h actual %h", want[63:0], result_low);
            failures++;
          end
        end
      end
    end
    pending = cipher_blocks.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_data;
  int          failures;
  int          pending;
  logic        hold_req;
  int          burst_left;

  aes128_block_cipher_unit DUT (.*);

  aes128_block_cipher_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

  // Receiver: stall on a changing pattern, with a long hold-off on request.
  initial begin
    int pat;
    int cnt;
    out_stall = 1'b0;
    pat = 0;
    cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      cnt++;
      if (cnt % 64 == 0) pat = $urandom_range(3);
      case (pat)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3) == 0);
        2: out_stall <= ($urandom_range(3) != 0);
        default: out_stall <= cnt[0];
      endcase
    end
  end

  // Offer one block in bursts; return once it has been accepted.
  task automatic send_block(input logic m, input logic [63:0] hi, input logic [63:0] lo);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    mode <= m;
    block_high <= hi;
    block_low <= lo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_key(input logic idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_half();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_blocks(input int n, input bit pause_mid);
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) drain();
      send_block(1'($urandom_range(1)), rand_half(), rand_half());
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    mode = 1'b0;
    block_high = '0;
    block_low = '0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    hold_req = 1'b0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // All-zero key: extremes and alternating bits in both directions.
    write_key(1'b0, 64'h0);
    write_key(1'b1, 64'h0);
    for (int m = 0; m < 2; m++) begin
      send_block(m[0], 64'h0, 64'h0);
      send_block(m[0], '1, '1);
      send_block(m[0], 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      send_block(m[0], 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    end
    drain();

    // Standard key and its published vector; receiver holds off meanwhile.
    write_key(1'b0, 64'h0001_0203_0405_0607);
    write_key(1'b1, 64'h0809_0a0b_0c0d_0e0f);
    send_block(1'b0, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    send_block(1'b1, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
    hold_req = 1'b1;
    random_blocks(150, 1'b0);
    drain();

    // All-ones key, with a pause for a full drain halfway.
    write_key(1'b0, '1);
    write_key(1'b1, '1);
    send_block(1'b0, '1, '1);
    send_block(1'b1, '1, '1);
    random_blocks(150, 1'b1);
    drain();

    // Rewrite one half only, then the other.
    write_key(1'b1, {$urandom, $urandom});
    random_blocks(150, 1'b0);
    drain();
    write_key(1'b0, {$urandom, $urandom});
    random_blocks(150, 1'b0);
    drain();

    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
